// File: sv/srt_pkg.sv
// ----------------------------------------------------------------------------
// srt_pkg: shared types and constants for the scale/rotate/translate block
// Fixed-point formats, sine polynomial coefficients and register indexes.
// ----------------------------------------------------------------------------
package srt_pkg;

  localparam int SCALE_WIDTH     = 16;
  localparam int SCALE_FRAC      = 8;
  localparam int TRIG_FRAC       = 30;
  localparam int TRIG_WIDTH      = 31;
  localparam int TRIG_PROD_WIDTH = 2 * TRIG_WIDTH;
  localparam int CFG_INDEX_WIDTH = 3;

  // 1.0 in Q8.8
  localparam logic [SCALE_WIDTH-1:0] SCALE_ONE = 16'd256;
  // 1.0 in Q1.30
  localparam logic [TRIG_WIDTH-1:0]  TRIG_ONE  = 31'h4000_0000;

  // sin(u*pi/2) = u*(A - u^2*(B - C*u^2)), Q30
  localparam logic [TRIG_WIDTH-1:0] POLY_A = 31'd1686629713;
  localparam logic [TRIG_WIDTH-1:0] POLY_B = 31'd688904866;
  localparam logic [TRIG_WIDTH-1:0] POLY_C = 31'd76016977;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_SCALE_X  = 3'd0,
    REG_SCALE_Y  = 3'd1,
    REG_ANGLE    = 3'd2,
    REG_OFFSET_X = 3'd3,
    REG_OFFSET_Y = 3'd4
  } cfg_reg_t;

endpackage

// File: sv/srt_point_if.sv
// ----------------------------------------------------------------------------
// srt_point_if: point request channel
// Carries the direction command and one Q16.16 point per request.
// ----------------------------------------------------------------------------
interface srt_point_if #(
  parameter int COORD_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic                          command;
  logic signed [COORD_WIDTH-1:0] point_x;
  logic signed [COORD_WIDTH-1:0] point_y;

  modport source (output valid, command, point_x, point_y, input ready);
  modport sink   (input valid, command, point_x, point_y, output ready);
endinterface

// File: sv/srt_result_if.sv
// ----------------------------------------------------------------------------
// srt_result_if: result channel
// Carries the transformed point and its saturation flag.
// ----------------------------------------------------------------------------
interface srt_result_if #(
  parameter int COORD_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] out_x;
  logic signed [COORD_WIDTH-1:0] out_y;
  logic                          overflow;

  modport source (output valid, out_x, out_y, overflow, input ready);
  modport sink   (input valid, out_x, out_y, overflow, output ready);
endinterface

// File: sv/srt_cfg_if.sv
// ----------------------------------------------------------------------------
// srt_cfg_if: configuration write channel
// Carries a register index and the data to write.
// ----------------------------------------------------------------------------
interface srt_cfg_if import srt_pkg::*; #(
  parameter int DATA_WIDTH = 32
);
  logic                       valid;
  logic                       ready;
  logic [CFG_INDEX_WIDTH-1:0] index;
  logic [DATA_WIDTH-1:0]      data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: sv/scale_rotate_translate_point.sv
// ----------------------------------------------------------------------------
// scale_rotate_translate_point: 2D affine point transform
// Forward: scale per axis, rotate, translate. Inverse: untranslate,
// rotate back, divide by scale. Saturating Q16.16 results.
// ----------------------------------------------------------------------------
// Usage:
//   point  : request channel, command (0 forward, 1 inverse) and a Q16.16
//            point. A request is taken when valid and ready are both high.
//   result : one result per request, in order, with an overflow flag that
//            is set when either coordinate saturated.
//   cfg    : register writes (scale_x, scale_y, angle, offset_x, offset_y),
//            always ready. Write only while no request is in flight.
// From request to result a point passes ten arithmetic stages (scale, four
// sine polynomial steps, split rotation multiply, rounding, sum, translate
// or prescale, clamp or divider load), one restoring divider stage per
// quotient bit, and the output register.
// Throughput is one request per cycle; every stage moves on each cycle the
// output register is empty or being taken.
// When the receiver stalls, the whole pipeline holds and ready drops; no
// request is lost or repeated. Reset clears every valid bit and loads the
// registers with unit scale, zero angle and zero offset.
// ----------------------------------------------------------------------------
module scale_rotate_translate_point import srt_pkg::*; #(
  parameter int COORD_WIDTH = 32,
  parameter int ANGLE_WIDTH = 16
) (
  input  logic         clk,
  input  logic         rst,
  srt_point_if.sink    point,
  srt_result_if.source result,
  srt_cfg_if.sink      cfg
);

  localparam int CW  = COORD_WIDTH;
  localparam int AW  = ANGLE_WIDTH;
  localparam int FB  = AW - 2;          // angle bits inside a quadrant
  localparam int DW  = CW + 1;          // inverse difference
  localparam int PRW = CW + SCALE_WIDTH;// forward scale product
  localparam int AMW = CW + 7;          // rotation input magnitude
  localparam int LW  = AMW / 2;         // low split of the rotation multiply
  localparam int HW  = AMW - LW;
  localparam int PW  = AMW + TRIG_WIDTH;
  localparam int TW  = AMW + 1;         // rounded rotation term
  localparam int RW  = TW + 1;          // rotated coordinate
  localparam int SW  = RW + 1;          // translated coordinate
  localparam int NW  = RW + SCALE_FRAC; // divider numerator
  localparam int ND  = CW;              // quotient bits, one divider stage each

  localparam logic [AW-1:0] QUARTER = {2'b01, {FB{1'b0}}};
  localparam logic signed [SW-1:0] SMAX = {{(SW-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [SW-1:0] SMIN = ~SMAX;
  localparam logic [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

  // ---------------------------------------------------------------- config
  logic [SCALE_WIDTH-1:0] scale  [2];
  logic [AW-1:0]          angle;
  logic signed [CW-1:0]   offset [2];

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale[0]  <= SCALE_ONE;
      scale[1]  <= SCALE_ONE;
      angle     <= '0;
      offset[0] <= '0;
      offset[1] <= '0;
    end else if (cfg.valid) begin
      case (cfg_reg_t'(cfg.index))
        REG_SCALE_X:  scale[0]  <= cfg.data[SCALE_WIDTH-1:0];
        REG_SCALE_Y:  scale[1]  <= cfg.data[SCALE_WIDTH-1:0];
        REG_ANGLE:    angle     <= cfg.data[AW-1:0];
        REG_OFFSET_X: offset[0] <= cfg.data[CW-1:0];
        REG_OFFSET_Y: offset[1] <= cfg.data[CW-1:0];
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------------- flow ctrl
  // Advance every stage whenever the output register can take a value.
  logic ce;
  assign ce          = !result.valid || result.ready;
  assign point.ready = ce;

  // ---------------------------------------------------- stage 1: scale, angle
  logic                  inv1;
  logic [PRW-1:0]        prod1 [2];
  logic                  neg1  [2];
  logic signed [DW-1:0]  dif1  [2];
  logic [TRIG_WIDTH-1:0] t1    [2];
  logic                  qs1   [2];

  logic [PRW-1:0]        prod1_next [2];
  logic                  neg1_next  [2];
  logic signed [DW-1:0]  dif1_next  [2];
  logic [TRIG_WIDTH-1:0] t1_next    [2];
  logic                  qs1_next   [2];

  always_comb begin
    logic [AW-1:0]         rot;
    logic [AW-1:0]         ang;
    logic [TRIG_WIDTH-1:0] tf;
    logic [CW-1:0]         pin [2];
    logic [CW-1:0]         pmag;
    rot    = point.command ? AW'(~angle + 1'b1) : angle;
    pin[0] = point.point_x;
    pin[1] = point.point_y;
    for (int k = 0; k < 2; k++) begin
      // k = 0 sine, k = 1 cosine (quarter turn ahead)
      ang = (k == 0) ? rot : AW'(rot + QUARTER);
      tf  = {{(TRIG_WIDTH-FB){1'b0}}, ang[FB-1:0]} << (TRIG_FRAC - FB);
      t1_next[k]  = ang[AW-2] ? TRIG_ONE - tf : tf;
      qs1_next[k] = ang[AW-1];
    end
    for (int j = 0; j < 2; j++) begin
      pmag          = pin[j][CW-1] ? ~pin[j] + 1'b1 : pin[j];
      prod1_next[j] = PRW'(pmag) * PRW'(scale[j]);
      neg1_next[j]  = pin[j][CW-1];
      dif1_next[j]  = $signed({pin[j][CW-1], pin[j]}) -
                      $signed({offset[j][CW-1], offset[j]});
    end
  end

  // --------------------------------------- stage 2: round scale, square angle
  logic                  inv2;
  logic [AMW-1:0]        axm2 [2];
  logic                  axn2 [2];
  logic [TRIG_WIDTH-1:0] t2   [2];
  logic                  qs2  [2];
  logic [TRIG_WIDTH-1:0] u2_2 [2];

  logic [AMW-1:0]        axm2_next [2];
  logic                  axn2_next [2];
  logic [TRIG_WIDTH-1:0] u2_2_next [2];

  always_comb begin
    logic [PRW-1:0]             fm;
    logic [DW-1:0]              dm;
    logic [TRIG_PROD_WIDTH-1:0] sq;
    for (int j = 0; j < 2; j++) begin
      fm = (prod1[j] + (PRW'(1) << (SCALE_FRAC - 1))) >> SCALE_FRAC;
      dm = dif1[j][DW-1] ? ~dif1[j] + 1'b1 : dif1[j];
      axm2_next[j] = inv1 ? AMW'(dm) : AMW'(fm);
      axn2_next[j] = inv1 ? dif1[j][DW-1] : neg1[j];
    end
    for (int k = 0; k < 2; k++) begin
      sq = TRIG_PROD_WIDTH'(t1[k]) * TRIG_PROD_WIDTH'(t1[k]);
      u2_2_next[k] = sq[TRIG_FRAC +: TRIG_WIDTH];
    end
  end

  // ------------------------------------------ stages 3 to 5: sine polynomial
  logic                  inv3, inv4, inv5;
  logic [AMW-1:0]        axm3 [2], axm4 [2], axm5 [2];
  logic                  axn3 [2], axn4 [2], axn5 [2];
  logic [TRIG_WIDTH-1:0] t3 [2], t4 [2];
  logic                  qs3 [2], qs4 [2], qs5 [2];
  logic [TRIG_WIDTH-1:0] u2_3 [2];
  logic [TRIG_WIDTH-1:0] cu3 [2], w4 [2], p5 [2];

  logic [TRIG_WIDTH-1:0] cu3_next [2], w4_next [2], p5_next [2];

  always_comb begin
    logic [TRIG_PROD_WIDTH-1:0] m3, m4, m5;
    for (int k = 0; k < 2; k++) begin
      m3 = TRIG_PROD_WIDTH'(POLY_C) * TRIG_PROD_WIDTH'(u2_2[k]);
      cu3_next[k] = m3[TRIG_FRAC +: TRIG_WIDTH];
      m4 = TRIG_PROD_WIDTH'(u2_3[k]) * TRIG_PROD_WIDTH'(POLY_B - cu3[k]);
      w4_next[k] = m4[TRIG_FRAC +: TRIG_WIDTH];
      m5 = TRIG_PROD_WIDTH'(t4[k]) * TRIG_PROD_WIDTH'(POLY_A - w4[k]);
      p5_next[k] = m5[TRIG_FRAC +: TRIG_WIDTH];
    end
  end

  // ------------------------------------- stage 6: split rotation products
  // Index [j][k]: axis j times sine (k = 0) or cosine (k = 1).
  logic                    inv6;
  logic [LW+TRIG_WIDTH-1:0] pl6 [2][2];
  logic [HW+TRIG_WIDTH-1:0] ph6 [2][2];
  logic                    n6  [2][2];

  // ----------------------------------------- stage 7: round each term
  logic                 inv7;
  logic signed [TW-1:0] term7 [2][2];
  logic signed [TW-1:0] term7_next [2][2];

  always_comb begin
    logic [PW-1:0]  sum;
    logic [AMW-1:0] mg;
    for (int j = 0; j < 2; j++) begin
      for (int k = 0; k < 2; k++) begin
        sum = (PW'(ph6[j][k]) << LW) + PW'(pl6[j][k]) +
              (PW'(1) << (TRIG_FRAC - 1));
        mg  = sum[TRIG_FRAC +: AMW];
        term7_next[j][k] = n6[j][k] ? -$signed({1'b0, mg}) : $signed({1'b0, mg});
      end
    end
  end

  // ----------------------------------------- stage 8: combine rotation terms
  logic                 inv8;
  logic signed [RW-1:0] r8 [2];

  // ------------------------------ stage 9: translate or prescale for divide
  logic                 inv9;
  logic signed [SW-1:0] s9   [2];
  logic [NW-1:0]        num9 [2];
  logic                 neg9 [2];

  logic [NW-1:0]        num9_next [2];

  always_comb begin
    logic [RW-1:0] rm;
    for (int j = 0; j < 2; j++) begin
      rm = r8[j][RW-1] ? ~r8[j] + 1'b1 : r8[j];
      num9_next[j] = (NW'(rm) << SCALE_FRAC) + NW'(scale[j] >> 1);
    end
  end

  // ---------------------------------------------------- divider stages
  // Stage 0 loads the remainder with the high numerator bits (or the
  // clamped forward value into the quotient register); each later stage
  // retires one quotient bit.
  logic                   dv   [ND+1];
  logic                   dinv [ND+1];
  logic [SCALE_WIDTH-1:0] drem [ND+1][2];
  logic [CW-1:0]          dlq  [ND+1][2];
  logic                   dsat [ND+1][2];
  logic                   dneg [ND+1][2];

  logic [SCALE_WIDTH-1:0] drem_next [ND+1][2];
  logic [CW-1:0]          dlq_next  [ND+1][2];
  logic                   dsat_next [2];

  always_comb begin
    logic [SCALE_WIDTH:0] hi;
    logic [SCALE_WIDTH:0] rx;
    logic                 ge;
    for (int j = 0; j < 2; j++) begin
      hi = num9[j][NW-1:CW];
      if (!inv9) begin
        drem_next[0][j] = '0;
        if (s9[j] > SMAX) begin
          dlq_next[0][j] = CMAX;
          dsat_next[j]   = 1'b1;
        end else if (s9[j] < SMIN) begin
          dlq_next[0][j] = CMIN;
          dsat_next[j]   = 1'b1;
        end else begin
          dlq_next[0][j] = s9[j][CW-1:0];
          dsat_next[j]   = 1'b0;
        end
      end else if (scale[j] == '0) begin
        // zero scale: zero stays zero, anything else saturates
        drem_next[0][j] = '0;
        dlq_next[0][j]  = '0;
        dsat_next[j]    = (num9[j] != '0);
      end else begin
        drem_next[0][j] = hi[SCALE_WIDTH-1:0];
        dlq_next[0][j]  = num9[j][CW-1:0];
        dsat_next[j]    = (hi >= {1'b0, scale[j]});
      end
      for (int k = 1; k <= ND; k++) begin
        rx = {drem[k-1][j], dlq[k-1][j][CW-1]};
        ge = (rx >= {1'b0, scale[j]});
        if (dinv[k-1] && scale[j] != '0) begin
          drem_next[k][j] = ge ? SCALE_WIDTH'(rx - {1'b0, scale[j]})
                               : rx[SCALE_WIDTH-1:0];
          dlq_next[k][j]  = {dlq[k-1][j][CW-2:0], ge};
        end else begin
          drem_next[k][j] = drem[k-1][j];
          dlq_next[k][j]  = dlq[k-1][j];
        end
      end
    end
  end

  // ----------------------------------------------------- output formatting
  logic [CW-1:0] val_next [2];
  logic          ovf_next [2];

  always_comb begin
    logic [CW-1:0] q;
    logic          n;
    for (int j = 0; j < 2; j++) begin
      q = dlq[ND][j];
      n = dneg[ND][j];
      if (!dinv[ND]) begin
        val_next[j] = q;
        ovf_next[j] = dsat[ND][j];
      end else if (dsat[ND][j]) begin
        val_next[j] = n ? CMIN : CMAX;
        ovf_next[j] = 1'b1;
      end else if (n) begin
        // magnitude up to 2^(CW-1) still fits a negative result
        ovf_next[j] = q[CW-1] && (q[CW-2:0] != '0);
        val_next[j] = ovf_next[j] ? CMIN : ~q + 1'b1;
      end else begin
        ovf_next[j] = q[CW-1];
        val_next[j] = ovf_next[j] ? CMAX : q;
      end
    end
  end

  // ------------------------------------------------------------ valid bits
  logic v1, v2, v3, v4, v5, v6, v7, v8, v9;

  always_ff @(posedge clk) begin
    if (rst) begin
      {v1, v2, v3, v4, v5, v6, v7, v8, v9} <= '0;
      for (int k = 0; k <= ND; k++) dv[k] <= 1'b0;
      result.valid <= 1'b0;
    end else if (ce) begin
      v1 <= point.valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
      v7 <= v6;
      v8 <= v7;
      v9 <= v8;
      dv[0] <= v9;
      for (int k = 1; k <= ND; k++) dv[k] <= dv[k-1];
      result.valid <= dv[ND];
    end
  end

  // -------------------------------------------------------------- payload
  always_ff @(posedge clk) begin
    if (ce) begin
      inv1 <= point.command;
      inv2 <= inv1;
      inv3 <= inv2;
      inv4 <= inv3;
      inv5 <= inv4;
      inv6 <= inv5;
      inv7 <= inv6;
      inv8 <= inv7;
      inv9 <= inv8;
      dinv[0] <= inv9;
      for (int k = 1; k <= ND; k++) dinv[k] <= dinv[k-1];

      for (int k = 0; k < 2; k++) begin
        t1[k]   <= t1_next[k];
        qs1[k]  <= qs1_next[k];
        t2[k]   <= t1[k];
        qs2[k]  <= qs1[k];
        u2_2[k] <= u2_2_next[k];
        t3[k]   <= t2[k];
        qs3[k]  <= qs2[k];
        u2_3[k] <= u2_2[k];
        cu3[k]  <= cu3_next[k];
        t4[k]   <= t3[k];
        qs4[k]  <= qs3[k];
        w4[k]   <= w4_next[k];
        qs5[k]  <= qs4[k];
        p5[k]   <= p5_next[k];
      end

      for (int j = 0; j < 2; j++) begin
        prod1[j] <= prod1_next[j];
        neg1[j]  <= neg1_next[j];
        dif1[j]  <= dif1_next[j];
        axm2[j]  <= axm2_next[j];
        axn2[j]  <= axn2_next[j];
        axm3[j]  <= axm2[j];
        axn3[j]  <= axn2[j];
        axm4[j]  <= axm3[j];
        axn4[j]  <= axn3[j];
        axm5[j]  <= axm4[j];
        axn5[j]  <= axn4[j];
        for (int k = 0; k < 2; k++) begin
          pl6[j][k]   <= (LW+TRIG_WIDTH)'(axm5[j][LW-1:0]) * (LW+TRIG_WIDTH)'(p5[k]);
          ph6[j][k]   <= (HW+TRIG_WIDTH)'(axm5[j][AMW-1:LW]) * (HW+TRIG_WIDTH)'(p5[k]);
          n6[j][k]    <= axn5[j] ^ qs5[k];
          term7[j][k] <= term7_next[j][k];
        end
        s9[j]   <= SW'(r8[j]) + SW'(offset[j]);
        num9[j] <= num9_next[j];
        neg9[j] <= r8[j][RW-1];
        dsat[0][j] <= dsat_next[j];
        dneg[0][j] <= neg9[j];
        for (int k = 0; k <= ND; k++) begin
          drem[k][j] <= drem_next[k][j];
          dlq[k][j]  <= dlq_next[k][j];
        end
        for (int k = 1; k <= ND; k++) begin
          dsat[k][j] <= dsat[k-1][j];
          dneg[k][j] <= dneg[k-1][j];
        end
      end

      // x' = x*cos - y*sin, y' = x*sin + y*cos
      r8[0] <= RW'(term7[0][1]) - RW'(term7[1][0]);
      r8[1] <= RW'(term7[0][0]) + RW'(term7[1][1]);

      result.out_x    <= val_next[0];
      result.out_y    <= val_next[1];
      result.overflow <= ovf_next[0] | ovf_next[1];
    end
  end

endmodule
